// ----- src/wosc_pkg.sv -----
package wosc_pkg;

  // Default build values for the oscillator
  localparam int unsigned PhaseStepsDef       = 1024;
  localparam int unsigned PeakToPeakDef       = 32768;
  localparam int unsigned StepFractionBitsDef = 16;

  // Fixed field widths
  localparam int unsigned TickW     = 32;
  localparam int unsigned StepW     = 26;
  localparam int unsigned PulseW    = 16;
  localparam int unsigned WaveSelW  = 2;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 32;

  // Configuration register indexes
  typedef enum logic [CfgIndexW-1:0] {
    REG_WAVE_SEL   = 2'd0,
    REG_PHASE_STEP = 2'd1,
    REG_PULSE_W    = 2'd2
  } cfg_reg_e;

  // Waveform selector codes
  typedef enum logic [WaveSelW-1:0] {
    WAVE_SAW   = 2'd0,
    WAVE_TRI   = 2'd1,
    WAVE_PULSE = 2'd2
  } wave_e;

endpackage

// ----- src/wavetable_oscillator.sv -----
// Channel    | Dir | Signals                               | Payload
// -----------+-----+---------------------------------------+------------------------------
// s_axis     | in  | s_axis_tvalid/tready/tdata[7:0]       | [0] advance
// m_axis     | out | m_axis_tvalid/tready/tdata[15:0]      | [15:0] sample (signed)
// cfg        | in  | cfg_valid_i/ready_o/index_i/data_i    | index 0 wave, 1 step, 2 width
//
// A request, once taken, steps the sequencer through phase, wave, diff and out; the
// result then sits in the output register, and a new request is accepted only once
// the sequencer is back in idle. The single 32x26 multiplier is used twice per
// request (tick times phase step, then peak-to-peak times position).
// s_axis_tready is high only while the sequencer is idle; a held result stalls
// the last step until m_axis accepts. Reset clears the tick count, config registers,
// sequencer and output valid. cfg is always ready.
module wavetable_oscillator
  import wosc_pkg::*;
#(
  parameter int unsigned PHASE_STEPS        = PhaseStepsDef,
  parameter int unsigned PEAK_TO_PEAK       = PeakToPeakDef,
  parameter int unsigned STEP_FRACTION_BITS = StepFractionBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,   // [0] advance, [7:1] zero
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [SampleW-1:0]   m_axis_tdata,   // [15:0] sample
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned IdxW  = $clog2(PHASE_STEPS);
  localparam int unsigned PtpW  = $clog2(PEAK_TO_PEAK + 1);
  localparam int unsigned MW    = PtpW + IdxW + 1;
  localparam int unsigned NumW  = MW + 2;
  localparam int unsigned ProdW = TickW + StepW;
  localparam int unsigned CmpW  = 2 * IdxW + PulseW + 1;
  localparam logic signed [NumW-1:0] HalfN =
      NumW'(PEAK_TO_PEAK / 2) <<< IdxW;
  localparam logic signed [NumW-1:0] RoundBias = NumW'(PHASE_STEPS - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PHASE = 5'b00010,
    ST_WAVE  = 5'b00100,
    ST_DIFF  = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [WaveSelW-1:0]    wave_sel_q;
  logic [StepW-1:0]       phase_step_q;
  logic [PulseW-1:0]      pulse_width_q;
  logic [TickW-1:0]       tick_q;
  logic                   adv_q;
  logic [ProdW-1:0]       prod_q, prod_d;
  logic                   tri_hi_q, pulse_hi_q;
  logic signed [NumW-1:0] num_q, num_d;
  logic                   out_valid_q;
  logic [SampleW-1:0]     sample_q;

  logic [TickW-1:0]       mul_a;
  logic [StepW-1:0]       mul_b;
  logic [IdxW-1:0]        pos;
  logic [IdxW:0]          wave_op;
  logic signed [NumW-1:0] m_ext;
  logic signed [NumW-1:0] rounded, shifted;
  logic signed [NumW+SampleW-1:0] ext;
  logic                   in_req, out_free;

  assign in_req        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Table position from the phase product
  assign pos = prod_q[STEP_FRACTION_BITS +: IdxW];

  // Multiplier operand for the waveform step
  always_comb begin
    case (wave_sel_q)
      WAVE_TRI: wave_op = {pos[IdxW-2:0], 1'b0};
      default:  wave_op = {1'b0, pos};
    endcase
  end

  // Shared multiplier
  always_comb begin
    if (state_q == ST_WAVE) begin
      mul_a = TickW'(PEAK_TO_PEAK);
      mul_b = StepW'(wave_op);
    end else begin
      mul_a = tick_q;
      mul_b = phase_step_q;
    end
    prod_d = ProdW'(mul_a) * ProdW'(mul_b);
  end

  // Numerator ahead of the divide by table size
  assign m_ext = NumW'(prod_q[MW-1:0]);
  always_comb begin
    case (wave_sel_q)
      WAVE_SAW:   num_d = m_ext - HalfN;
      WAVE_TRI:   num_d = tri_hi_q ? (HalfN - m_ext) : (m_ext - HalfN);
      WAVE_PULSE: num_d = pulse_hi_q ? HalfN : -HalfN;
      default:    num_d = '0;
    endcase
  end

  // Divide by table size, truncating toward zero
  assign rounded = num_q + (num_q[NumW-1] ? RoundBias : '0);
  assign shifted = rounded >>> IdxW;
  assign ext     = {{SampleW{shifted[NumW-1]}}, shifted};

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_req) state_d = ST_PHASE;
      ST_PHASE: state_d = ST_WAVE;
      ST_WAVE:  state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      wave_sel_q    <= '0;
      phase_step_q  <= '0;
      pulse_width_q <= '0;
      tick_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_WAVE_SEL:   wave_sel_q    <= cfg_data_i[WaveSelW-1:0];
          REG_PHASE_STEP: phase_step_q  <= cfg_data_i[StepW-1:0];
          REG_PULSE_W:    pulse_width_q <= cfg_data_i[PulseW-1:0];
          default: ;
        endcase
      end
      // tick advances, when the advance bit is set, as the phase product is taken
      if (state_q == ST_PHASE && adv_q) begin
        tick_q <= tick_q + 1'b1;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_req) begin
      adv_q <= s_axis_tdata[0];
    end
    if (state_q == ST_PHASE || state_q == ST_WAVE) begin
      prod_q <= prod_d;
    end
    if (state_q == ST_WAVE) begin
      tri_hi_q   <= pos[IdxW-1];
      pulse_hi_q <= ((CmpW'(pos) << (IdxW + 1)) < CmpW'(pulse_width_q));
    end
    if (state_q == ST_DIFF) begin
      num_q <= num_d;
    end
    if (state_q == ST_OUT && out_free) begin
      sample_q <= ext[SampleW-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = sample_q;

endmodule

// ----- src/wosc_checker.sv -----
module wosc_checker
  import wosc_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [SampleW-1:0]   m_axis_tdata
);

  // A request keeps the input side busy on the following cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a request");

  // A result never appears the cycle after its request
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("result too early");

  // A new result only shows up together with an idle input side
  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result while sequencer busy");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind wavetable_oscillator wosc_checker u_wosc_checker (.*);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import wosc_pkg::*;

  localparam longint     PosSteps  = PhaseStepsDef;
  localparam longint     FullSwing = PeakToPeakDef;
  localparam longint     HalfSwing = PeakToPeakDef / 2;
  localparam int unsigned FracBits  = StepFractionBitsDef;

  // Codes the package leaves unnamed
  localparam logic [CfgIndexW-1:0] RegSpare  = 2'd3;
  localparam logic [WaveSelW-1:0]  WaveSpare = 2'd3;

  localparam logic [StepW-1:0]  StepMax      = '1;
  localparam logic [PulseW-1:0] WidthMax     = '1;
  localparam int                RandomReqs   = 750;
  localparam int                LongHold     = 300;
  localparam int                DrainCycles  = 20;
  localparam int                CycleLimit   = 400000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [SampleW-1:0]   m_axis_tdata;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;

  wavetable_oscillator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Oscillator shadow state
  logic [WaveSelW-1:0] osc_wave  = WAVE_SAW;
  logic [StepW-1:0]    osc_step  = '0;
  logic [PulseW-1:0]   osc_width = '0;
  logic [TickW-1:0]    osc_tick  = '0;

  logic                 pending_requests[$];
  logic [SampleW-1:0]   expected_samples[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  gap_left = 0;
  int  burst_left = 1;
  int  hold_left = 0;
  bit  hold_taken = 1'b0;
  bit  long_hold_req = 1'b0;
  logic [15:0] stall_bits = '1;
  logic [3:0]  stall_pos = '0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Sample for the current tick, then step the tick on advance
  function automatic logic [SampleW-1:0] next_sample(input logic advance);
    logic [63:0] product;
    longint      pos;
    longint      value;
    product = 64'(osc_tick) * 64'(osc_step);
    pos = longint'((product >> FracBits) & 64'(PosSteps - 1));
    case (osc_wave)
      WAVE_SAW:
        value = (FullSwing * pos - HalfSwing * PosSteps) / PosSteps;
      WAVE_TRI:
        if (pos < PosSteps / 2) begin
          value = (2 * FullSwing * pos - HalfSwing * PosSteps) / PosSteps;
        end else begin
          value = (HalfSwing * PosSteps - 2 * FullSwing * (pos - PosSteps / 2)) / PosSteps;
        end
      WAVE_PULSE:
        value = (pos * 2 * PosSteps < longint'(osc_width)) ? HalfSwing : -HalfSwing;
      default:
        value = 0;
    endcase
    if (advance) osc_tick = osc_tick + 1'b1;
    return value[SampleW-1:0];
  endfunction

  // Request driver: bursts with random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_samples.push_back(next_sample(s_axis_tdata[0]));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          s_axis_tdata  <= {{(InDataW-1){1'b0}}, pending_requests.pop_front()};
          s_axis_tvalid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result ready: random stall pattern plus one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (long_hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = LongHold;
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_pos == 0)
        stall_bits = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom());
      m_axis_tready <= stall_bits[stall_pos];
      stall_pos = stall_pos + 1'b1;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_samples.size() == 0) begin
        $error("unexpected sample %0d", $signed(m_axis_tdata));
        error_count++;
      end else begin
        logic [SampleW-1:0] want;
        want = expected_samples.pop_front();
        if (m_axis_tdata !== want) begin
          $error("sample mismatch: expected %0d, actual %0d",
                 $signed(want), $signed(m_axis_tdata));
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_WAVE_SEL:   osc_wave  = value[WaveSelW-1:0];
      REG_PHASE_STEP: osc_step  = value[StepW-1:0];
      REG_PULSE_W:    osc_width = value[PulseW-1:0];
      default: ;
    endcase
  endtask

  // All three registers, junk in the unused upper bits
  task automatic set_osc(input logic [WaveSelW-1:0] wave, input logic [StepW-1:0] step,
                         input logic [PulseW-1:0] width);
    write_reg(REG_WAVE_SEL, CfgDataW'({$urandom(), wave}));
    write_reg(REG_PHASE_STEP, CfgDataW'({$urandom(), step}));
    write_reg(REG_PULSE_W, CfgDataW'({$urandom(), width}));
  endtask

  // Checked on the falling edge so the driver's updates have settled
  task automatic wait_idle();
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_samples.size() != 0)
      @(negedge clk_i);
  endtask

  // One request at a given setting; with tick at 1 the step picks the position
  task automatic probe(input logic [WaveSelW-1:0] wave, input logic [StepW-1:0] step,
                       input logic [PulseW-1:0] width, input logic advance);
    set_osc(wave, step, width);
    pending_requests.push_back(advance);
    wait_idle();
  endtask

  initial begin
    int sent;
    int burst;
    logic [WaveSelW-1:0] wave;
    logic [StepW-1:0]    step;
    logic [PulseW-1:0]   width;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: tick 0 first, then positions picked at tick 1
    probe(WAVE_SAW, '0, '0, 1'b1);
    probe(WAVE_SAW, StepW'(0) << FracBits, '0, 1'b0);
    probe(WAVE_SAW, StepW'(1) << FracBits, '0, 1'b0);
    probe(WAVE_SAW, StepW'(511) << FracBits, '0, 1'b0);
    probe(WAVE_SAW, StepW'(512) << FracBits, '0, 1'b0);
    probe(WAVE_SAW, StepMax, '0, 1'b0);
    probe(WAVE_TRI, StepW'(0) << FracBits, '0, 1'b0);
    probe(WAVE_TRI, StepW'(511) << FracBits, '0, 1'b0);
    probe(WAVE_TRI, StepW'(512) << FracBits, '0, 1'b0);
    probe(WAVE_TRI, StepW'(513) << FracBits, '0, 1'b0);
    probe(WAVE_TRI, StepMax, '0, 1'b0);
    // pulse edges around the width threshold
    probe(WAVE_PULSE, '0, '0, 1'b0);
    probe(WAVE_PULSE, '0, 16'd1, 1'b0);
    probe(WAVE_PULSE, '0, 16'd2048, 1'b0);
    probe(WAVE_PULSE, StepW'(1) << FracBits, 16'd2048, 1'b0);
    probe(WAVE_PULSE, StepW'(31) << FracBits, WidthMax, 1'b0);
    probe(WAVE_PULSE, StepW'(32) << FracBits, WidthMax, 1'b0);
    probe(WAVE_PULSE, StepMax, WidthMax, 1'b0);
    // unused selector and a write to the spare index
    probe(WaveSpare, StepW'(100) << FracBits, WidthMax, 1'b0);
    write_reg(RegSpare, $urandom());
    probe(WAVE_SAW, StepMax, '0, 1'b1);

    // Random bursts of requests, each burst under its own setting
    sent = 0;
    while (sent < RandomReqs) begin
      case ($urandom_range(0, 9))
        0, 1, 2: wave = WAVE_SAW;
        3, 4, 5: wave = WAVE_TRI;
        6, 7, 8: wave = WAVE_PULSE;
        default: wave = WaveSpare;
      endcase
      case ($urandom_range(0, 4))
        0:       step = '0;
        1:       step = StepMax;
        2:       step = StepW'($urandom_range(1, 1 << FracBits));
        3:       step = StepW'($urandom());
        default: step = StepW'($urandom_range(0, 1 << 22));
      endcase
      case ($urandom_range(0, 3))
        0:       width = '0;
        1:       width = WidthMax;
        default: width = PulseW'($urandom());
      endcase
      set_osc(wave, step, width);
      if ($urandom_range(0, 3) == 0) write_reg(RegSpare, $urandom());
      burst = $urandom_range(20, 80);
      repeat (burst) pending_requests.push_back($urandom_range(0, 3) != 0);
      sent += burst;
      long_hold_req = 1'b1;
      wait_idle();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
